[src/demand_allocated_paged_byte_memory_assert.svh]
// Assertion macros for the demand allocated paged byte memory.
// They expect clk_i and rst_ni in the scope of use.
`ifndef DEMAND_ALLOCATED_PAGED_BYTE_MEMORY_ASSERT_SVH
`define DEMAND_ALLOCATED_PAGED_BYTE_MEMORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAPBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAPBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dapbm_pkg.sv]
// ----------------------------------------------------------------------------
// dapbm_pkg
// Shared types and constants of the demand allocated paged byte memory.
// ----------------------------------------------------------------------------
`default_nettype none

package dapbm_pkg;

  localparam int unsigned NUM_FRAMES_DEF   = 16;
  localparam int unsigned PAGE_BITS_DEF    = 12;
  localparam int unsigned ADDRESS_BITS_DEF = 32;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned MAX_FRAME_W = 10;
  localparam int unsigned MAX_PAGE_W  = 16;

  // Both queues must have a power of two depth.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_READ_MISS  = 2'd1,
    STATUS_WRITE_DROP = 2'd2
  } status_e;

  typedef struct packed {
    op_e               opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    status_e           status;
    logic              page_allocated;
  } out_word_t;

  typedef struct packed {
    logic                   access;
    op_e                    op;
    logic [MAX_FRAME_W-1:0] frame;
    logic [MAX_PAGE_W-1:0]  offset;
    logic [DATA_W-1:0]      data;
    status_e                status;
    logic                   alloc;
  } cmd_t;

endpackage

`default_nettype wire

[src/dapbm_fifo.sv]
// ----------------------------------------------------------------------------
// dapbm_fifo
// Small first-in first-out queue of words with full, empty and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module dapbm_fifo
  import dapbm_pkg::*;
#(
  parameter type         word_t = logic,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire word_t             wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output word_t                  rdata_o,
  output logic                   empty_o,
  output logic [QCNT_W-1:0]      count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  word_t             slot_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];
  assign count_o = QCNT_W'(cnt_q);

  always_comb begin
    wptr_d = do_push ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/dapbm_front.sv]
// ----------------------------------------------------------------------------
// dapbm_front
// Page tag table: looks up each accepted word, claims frames on write misses
// and issues a classified command to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dapbm_front
  import dapbm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES   = NUM_FRAMES_DEF,
  parameter int unsigned PAGE_BITS    = PAGE_BITS_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_word_t in_word_i,
  output cmd_t          cmd_o
);

  localparam int unsigned TAG_W   = ADDRESS_BITS - PAGE_BITS;
  localparam int unsigned FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_FRAMES + 1);

  logic [TAG_W-1:0]      tags_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      used_q, used_d;

  logic [TAG_W-1:0]      page;
  logic [PAGE_BITS-1:0]  offset;
  logic [NUM_FRAMES-1:0] hit_vec;
  logic [FRAME_W-1:0]    hit_idx;
  logic [FRAME_W-1:0]    frame;
  logic                  hit, room, is_write, alloc;

  assign page     = in_word_i.address[ADDRESS_BITS-1:PAGE_BITS];
  assign offset   = in_word_i.address[PAGE_BITS-1:0];
  assign is_write = (in_word_i.opcode == OP_WRITE);

  always_comb begin
    hit_idx = '0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      hit_vec[f] = valid_q[f] && (tags_q[f] == page);
      if (hit_vec[f]) begin
        hit_idx = hit_idx | FRAME_W'(f);
      end
    end
  end

  assign hit   = |hit_vec;
  assign room  = (used_q < CNT_W'(NUM_FRAMES));
  assign alloc = is_write && !hit && room;
  assign frame = hit ? hit_idx : used_q[FRAME_W-1:0];

  always_comb begin
    cmd_o.access = hit || alloc;
    cmd_o.op     = in_word_i.opcode;
    cmd_o.frame  = MAX_FRAME_W'(frame);
    cmd_o.offset = MAX_PAGE_W'(offset);
    cmd_o.data   = in_word_i.write_data;
    cmd_o.alloc  = alloc;
    if (hit || alloc) begin
      cmd_o.status = STATUS_OK;
    end else if (is_write) begin
      cmd_o.status = STATUS_WRITE_DROP;
    end else begin
      cmd_o.status = STATUS_READ_MISS;
    end
  end

  always_comb begin
    valid_d = valid_q;
    used_d  = used_q;
    if (accept_i && alloc) begin
      valid_d[used_q[FRAME_W-1:0]] = 1'b1;
      used_d = used_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && alloc) begin
      tags_q[used_q[FRAME_W-1:0]] <= page;
    end
  end

endmodule

`default_nettype wire

[src/dapbm_back.sv]
// ----------------------------------------------------------------------------
// dapbm_back
// Frame memory: clears all frames after reset, then carries out commands
// and forms one result word for each.
// ----------------------------------------------------------------------------
`default_nettype none

module dapbm_back
  import dapbm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_empty_i,
  input  wire cmd_t              cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic [QCNT_W-1:0] res_count_i,
  output logic                   res_push_o,
  output out_word_t              res_o,
  output logic                   clearing_o
);

  localparam int unsigned FRAME_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned MEM_DEPTH = NUM_FRAMES << PAGE_BITS;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  logic [DATA_W-1:0]         mem_q [MEM_DEPTH];
  logic [DATA_W-1:0]         rdata_q;
  logic                      clr_active_q, clr_active_d;
  logic [MEM_AW-1:0]         clr_addr_q, clr_addr_d;
  logic                      pend_q, pend_d;
  status_e                   pend_status_q;
  logic                      pend_alloc_q;
  logic                      pend_rd_q;

  logic                      issue, mem_we, mem_re;
  logic [FRAME_W+PAGE_BITS-1:0] cmd_addr;
  logic [MEM_AW-1:0]         mem_addr;
  logic [DATA_W-1:0]         mem_wdata;

  assign issue = !clr_active_q && !cmd_empty_i &&
                 ((QCNT_W + 1)'(res_count_i) + (QCNT_W + 1)'(pend_q)
                  < (QCNT_W + 1)'(QUEUE_DEPTH));

  assign cmd_addr  = {cmd_i.frame[FRAME_W-1:0], cmd_i.offset[PAGE_BITS-1:0]};
  assign mem_addr  = clr_active_q ? clr_addr_q : cmd_addr[MEM_AW-1:0];
  assign mem_we    = clr_active_q || (issue && cmd_i.access && (cmd_i.op == OP_WRITE));
  assign mem_re    = issue && cmd_i.access && (cmd_i.op == OP_READ);
  assign mem_wdata = clr_active_q ? '0 : cmd_i.data;

  assign cmd_pop_o  = issue;
  assign clearing_o = clr_active_q;
  assign res_push_o = pend_q;

  always_comb begin
    res_o.read_data      = pend_rd_q ? rdata_q : '0;
    res_o.status         = pend_status_q;
    res_o.page_allocated = pend_alloc_q;
  end

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + MEM_AW'(1);
      if (clr_addr_q == MEM_AW'(MEM_DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    pend_d = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      pend_q       <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_status_q <= cmd_i.status;
      pend_alloc_q  <= cmd_i.alloc;
      pend_rd_q     <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

endmodule

`default_nettype wire

[src/demand_allocated_paged_byte_memory.sv]
// ----------------------------------------------------------------------------
// demand_allocated_paged_byte_memory
// Sparse byte memory whose page frames are claimed on the first write.
// ----------------------------------------------------------------------------
// Input words enter through push and full and are accepted when push is high
// and full is low. Each word is a byte read or byte write at an address whose
// low PAGE_BITS bits are the offset and whose upper bits are the page number.
// Every accepted word gives exactly one result word, in order, shown while
// empty is low and taken when pop is high.
// An accepted word passes through the command queue, the back end's pending
// result register and the output queue before it is visible as a result.
// The back end issues a command only while its pending result and the output
// queue hold fewer than two words, and may issue while a result is pending.
// After reset all NUM_FRAMES << PAGE_BITS bytes of frame memory are swept to
// zero, one byte per cycle; full stays high during the sweep.
// When the receiver stalls, the output queue and then the command queue fill
// and full rises; no word is lost.
// Reads of unclaimed pages report a read miss. Writes that find no free frame
// are dropped and reported.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_allocated_paged_byte_memory
  import dapbm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES   = NUM_FRAMES_DEF,
  parameter int unsigned PAGE_BITS    = PAGE_BITS_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  input  wire in_word_t in_word_i,
  output logic          full,
  output logic          empty,
  input  wire logic     pop,
  output out_word_t     out_word_o
);

  cmd_t              cmd_in, cmd_out;
  logic              cmd_full, cmd_empty, cmd_pop;
  logic              accept, clearing;
  logic              res_push;
  out_word_t         res_word;
  logic [QCNT_W-1:0] res_count;

  assign full   = clearing || cmd_full;
  assign accept = push && !full;

  dapbm_front #(
    .NUM_FRAMES  (NUM_FRAMES),
    .PAGE_BITS   (PAGE_BITS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_word_i(in_word_i),
    .cmd_o    (cmd_in)
  );

  dapbm_fifo #(
    .word_t(cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty),
    .count_o()
  );

  dapbm_back #(
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_word),
    .clearing_o (clearing)
  );

  dapbm_fifo #(
    .word_t(out_word_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_word),
    .full_o (),
    .pop_i  (pop),
    .rdata_o(out_word_o),
    .empty_o(empty),
    .count_o(res_count)
  );

endmodule

`default_nettype wire

[src/dapbm_checker.sv]
// ----------------------------------------------------------------------------
// dapbm_checker
// Port level checks on the result words of the paged byte memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "demand_allocated_paged_byte_memory_assert.svh"

module dapbm_checker
  import dapbm_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_word_t out_word_i
);

  `DAPBM_ASSERT_SAME(a_fail_no_data, !empty && (out_word_i.status != STATUS_OK), (out_word_i.read_data == '0) && !out_word_i.page_allocated, "Failed access returned data or claimed a frame.")
  `DAPBM_ASSERT_SAME(a_alloc_is_write, !empty && out_word_i.page_allocated, (out_word_i.read_data == '0) && (out_word_i.status == STATUS_OK), "Frame claim reported with data or an error.")
  `DAPBM_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(out_word_i), "Stalled result word changed.")

endmodule

bind demand_allocated_paged_byte_memory dapbm_checker u_dapbm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_word_i(out_word_o)
);

`default_nettype wire
